// ===== hdl/erm_pkg.sv =====
// ----------------------------------------------------------------------------
// erm_pkg
// Shared widths, series constants and fixed-point helpers for the Euler-angle
// rotation matrix block.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;

    localparam int ANGLE_IN_W = 16;
    localparam int COEF_W     = 16;
    localparam int SHIFT_W    = 32;

    // internal Q30 datapath widths
    localparam int XW    = 31;
    localparam int X2W   = 32;
    localparam int ACCW  = 31;
    localparam int QW    = 30;
    localparam int RCPW  = 31;
    localparam int DIVW  = 8;
    localparam int SINW  = 32;
    localparam int SUMW  = 33;
    localparam int RR_W  = ANGLE_BITS - 1;
    localparam int RCP_SH = 33;

    localparam int NUM_TERMS   = 6;
    localparam int TERM_IDX_W  = 3;
    localparam int CELL_STAGES = 3;
    localparam int LANE_STAGES = 3 + CELL_STAGES * NUM_TERMS + 1;
    localparam int NUM_STAGES  = LANE_STAGES + 3;
    localparam int NUM_LANES   = 6;
    localparam int NUM_COEF    = 9;

    localparam logic [XW-1:0]         HALF_PI_Q30  = 31'd1686629713;
    localparam logic [ACCW-1:0]       Q30_ONE      = 31'h4000_0000;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));
    localparam logic [RR_W-1:0]       QUARTER_RR   = RR_W'(64'd1 << (ANGLE_BITS - 2));

    // horner divisors of the sine series and their reciprocals scaled by 2^33
    localparam logic [DIVW-1:0] SERIES_DIV [NUM_TERMS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [RCPW-1:0] SERIES_RCP [NUM_TERMS] = '{
        RCPW'((64'd1 << RCP_SH) / 64'd156),
        RCPW'((64'd1 << RCP_SH) / 64'd110),
        RCPW'((64'd1 << RCP_SH) / 64'd72),
        RCPW'((64'd1 << RCP_SH) / 64'd42),
        RCPW'((64'd1 << RCP_SH) / 64'd20),
        RCPW'((64'd1 << RCP_SH) / 64'd6)
    };

    localparam int COEF_SH = 30 - COEF_FRAC_BITS;
    localparam logic [SUMW:0] COEF_RND = (SUMW+1)'((64'd1 << COEF_SH) / 64'd2);
    localparam logic [SUMW:0] COEF_LIM = (SUMW+1)'(64'd1 << COEF_FRAC_BITS);

    typedef logic signed [SINW-1:0] q30_t;

    typedef struct packed {
        logic [XW-1:0]   x;
        logic [X2W-1:0]  x2;
        logic [ACCW-1:0] acc;
        logic            neg;
    } sine_data_t;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] x;
        logic signed [SHIFT_W-1:0] y;
        logic signed [SHIFT_W-1:0] z;
    } shift_t;

    // q30 times q30, rounded half away from zero
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic [SINW-1:0]   ma;
        logic [SINW-1:0]   mb;
        logic [2*SINW-1:0] p;
        logic [SINW-1:0]   m;
        ma = a[SINW-1] ? SINW'(-a) : SINW'(a);
        mb = b[SINW-1] ? SINW'(-b) : SINW'(b);
        p  = (2*SINW)'(ma) * (2*SINW)'(mb) + ((2*SINW)'(1) << 29);
        m  = p[30 +: SINW];
        return (a[SINW-1] ^ b[SINW-1]) ? -q30_t'(m) : q30_t'(m);
    endfunction

    // q30 to coefficient format, rounded and saturated to +-1.0
    function automatic logic [COEF_W-1:0] to_coef(input logic signed [SUMW-1:0] v);
        logic signed [SUMW:0] ve;
        logic [SUMW:0]        m;
        logic [SUMW:0]        r;
        ve = (SUMW+1)'(v);
        m  = v[SUMW-1] ? (SUMW+1)'(-ve) : (SUMW+1)'(ve);
        m  = (m + COEF_RND) >> COEF_SH;
        if (m > COEF_LIM)
        begin
            m = COEF_LIM;
        end
        r = v[SUMW-1] ? (SUMW+1)'(-m) : m;
        return r[COEF_W-1:0];
    endfunction

endpackage

// ===== hdl/euler_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_rotation_matrix
// Rotation coefficients of an xyz Euler-angle transform, translation passed on.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries three angles (binary angle units,
// one full turn per 2^ANGLE_BITS) and a Q16.16 translation. Output channel
// out_valid/out_ready carries the nine Q1.14 coefficients and the unchanged
// translation. Every input transfer gives exactly one output transfer.
// One item per cycle is sustained while out_ready stays high. The
// 25 stages are three front stages, six series cells of three stages each,
// a final product stage, two product stages and a rounding stage.
// Each stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up: when the receiver stalls, new items
// keep entering until all 25 stages hold data, and only then in_ready drops.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module euler_rotation_matrix
    import erm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ANGLE_IN_W-1:0]     angle_x,
    input  logic [ANGLE_IN_W-1:0]     angle_y,
    input  logic [ANGLE_IN_W-1:0]     angle_z,
    input  logic signed [SHIFT_W-1:0] shift_x,
    input  logic signed [SHIFT_W-1:0] shift_y,
    input  logic signed [SHIFT_W-1:0] shift_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COEF_W-1:0]  rot_0_0,
    output logic signed [COEF_W-1:0]  rot_0_1,
    output logic signed [COEF_W-1:0]  rot_0_2,
    output logic signed [COEF_W-1:0]  rot_1_0,
    output logic signed [COEF_W-1:0]  rot_1_1,
    output logic signed [COEF_W-1:0]  rot_1_2,
    output logic signed [COEF_W-1:0]  rot_2_0,
    output logic signed [COEF_W-1:0]  rot_2_1,
    output logic signed [COEF_W-1:0]  rot_2_2,
    output logic signed [SHIFT_W-1:0] trans_x,
    output logic signed [SHIFT_W-1:0] trans_y,
    output logic signed [SHIFT_W-1:0] trans_z
);

    localparam int ST_C1  = LANE_STAGES;
    localparam int ST_C2  = LANE_STAGES + 1;
    localparam int ST_OUT = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] en;

    logic [ANGLE_IN_W-1:0] lane_angle [NUM_LANES];
    q30_t                  lane_sine  [NUM_LANES];
    shift_t                shift_reg  [NUM_STAGES];

    q30_t su, cu, sv, cv, sw, cw;

    // first product level
    q30_t susv_reg, cusv_reg, cvcw_reg, cvsw_reg, sucv_reg, cucv_reg;
    q30_t cusw_reg, cucw_reg, susw_reg, sucw_reg, sv1_reg, sw1_reg, cw1_reg;
    // second product level
    q30_t svswcw_a_reg, svsw_b_reg, cusvcw_reg, cusvsw_reg;
    q30_t cvcw2_reg, cvsw2_reg, sv2_reg, cusw2_reg, cucw2_reg, sucv2_reg;
    q30_t susw2_reg, sucw2_reg, cucv2_reg;

    logic [COEF_W-1:0] coef_reg  [NUM_COEF];
    logic [COEF_W-1:0] coef_next [NUM_COEF];

    // ready ripples back from the output register through empty stages
    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[ST_OUT];

    assign lane_angle[0] = angle_x;
    assign lane_angle[1] = angle_x;
    assign lane_angle[2] = angle_y;
    assign lane_angle[3] = angle_y;
    assign lane_angle[4] = angle_z;
    assign lane_angle[5] = angle_z;

    // even lanes give sines, odd lanes cosines
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        erm_sine_lane u_lane (
            .clk    (clk),
            .en     (en[LANE_STAGES-1:0]),
            .angle  (lane_angle[g]),
            .is_cos (1'(g % 2)),
            .sine   (lane_sine[g])
        );
    end

    assign su = lane_sine[0];
    assign cu = lane_sine[1];
    assign sv = lane_sine[2];
    assign cv = lane_sine[3];
    assign sw = lane_sine[4];
    assign cw = lane_sine[5];

    // translation rides alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            shift_reg[0] <= '{x: shift_x, y: shift_y, z: shift_z};
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                shift_reg[k] <= shift_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_C1])
        begin
            susv_reg <= mul30(su, sv);
            cusv_reg <= mul30(cu, sv);
            cvcw_reg <= mul30(cv, cw);
            cvsw_reg <= mul30(cv, sw);
            sucv_reg <= mul30(su, cv);
            cucv_reg <= mul30(cu, cv);
            cusw_reg <= mul30(cu, sw);
            cucw_reg <= mul30(cu, cw);
            susw_reg <= mul30(su, sw);
            sucw_reg <= mul30(su, cw);
            sv1_reg  <= sv;
            sw1_reg  <= sw;
            cw1_reg  <= cw;
        end
        if (en[ST_C2])
        begin
            svswcw_a_reg <= mul30(susv_reg, cw1_reg);
            svsw_b_reg   <= mul30(susv_reg, sw1_reg);
            cusvcw_reg   <= mul30(cusv_reg, cw1_reg);
            cusvsw_reg   <= mul30(cusv_reg, sw1_reg);
            cvcw2_reg    <= cvcw_reg;
            cvsw2_reg    <= cvsw_reg;
            sv2_reg      <= sv1_reg;
            cusw2_reg    <= cusw_reg;
            cucw2_reg    <= cucw_reg;
            sucv2_reg    <= sucv_reg;
            susw2_reg    <= susw_reg;
            sucw2_reg    <= sucw_reg;
            cucv2_reg    <= cucv_reg;
        end
        if (en[ST_OUT])
        begin
            coef_reg <= coef_next;
        end
    end

    always_comb
    begin
        coef_next[0] = to_coef(SUMW'(cvcw2_reg));
        coef_next[1] = to_coef(SUMW'(cvsw2_reg));
        coef_next[2] = to_coef(SUMW'(sv2_reg));
        coef_next[3] = to_coef(-SUMW'(svswcw_a_reg) - SUMW'(cusw2_reg));
        coef_next[4] = to_coef(-SUMW'(svsw_b_reg) + SUMW'(cucw2_reg));
        coef_next[5] = to_coef(SUMW'(sucv2_reg));
        coef_next[6] = to_coef(-SUMW'(cusvcw_reg) + SUMW'(susw2_reg));
        coef_next[7] = to_coef(-SUMW'(cusvsw_reg) - SUMW'(sucw2_reg));
        coef_next[8] = to_coef(SUMW'(cucv2_reg));
    end

    assign rot_0_0 = coef_reg[0];
    assign rot_0_1 = coef_reg[1];
    assign rot_0_2 = coef_reg[2];
    assign rot_1_0 = coef_reg[3];
    assign rot_1_1 = coef_reg[4];
    assign rot_1_2 = coef_reg[5];
    assign rot_2_0 = coef_reg[6];
    assign rot_2_1 = coef_reg[7];
    assign rot_2_2 = coef_reg[8];
    assign trans_x = shift_reg[ST_OUT].x;
    assign trans_y = shift_reg[ST_OUT].y;
    assign trans_z = shift_reg[ST_OUT].z;

    // an empty output register never blocks the input
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready
    ) else $error("input blocked while output register empty");

    // input only stalls when every stage holds an item
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n) !in_ready |-> (&v_reg)
    ) else $error("input stalled with a bubble in the pipeline");

    // an input transfer always lands in the first stage
    a_transfer_lands: assert property (
        @(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> v_reg[0]
    ) else $error("accepted item lost at pipeline entry");

    // a stalled output keeps its item
    a_out_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(trans_x) && $stable(rot_1_1))
    ) else $error("stalled result changed");

endmodule

// ===== hdl/erm_series_cell.sv =====
// ----------------------------------------------------------------------------
// erm_series_cell
// One horner step of the sine series: acc = 1 - (x2 * acc) / div, in three
// register stages (product, reciprocal estimate, correction).
// ----------------------------------------------------------------------------
module erm_series_cell
    import erm_pkg::*;
(
    input  logic                  clk,
    input  logic [CELL_STAGES-1:0] en,
    input  logic [TERM_IDX_W-1:0] term_idx,
    input  sine_data_t            din,
    output sine_data_t            dout
);

    sine_data_t      a_reg;
    logic [X2W-1:0]  pa_reg;
    sine_data_t      b_reg;
    logic [X2W-1:0]  pb_reg;
    logic [QW-1:0]   q0_reg;
    sine_data_t      c_reg;

    logic [62:0]     prod_a;
    logic [62:0]     prod_b;
    logic [X2W-1:0]  qd;
    logic [X2W-1:0]  rem;
    logic [ACCW-1:0] quo;
    logic [DIVW-1:0] div;
    sine_data_t      c_next;

    assign div    = SERIES_DIV[term_idx];
    assign prod_a = 63'(din.x2) * 63'(din.acc);
    assign prod_b = 63'(pa_reg) * 63'(SERIES_RCP[term_idx]);

    // estimate is exact or one low
    always_comb
    begin
        qd     = X2W'(q0_reg) * X2W'(div);
        rem    = pb_reg - qd;
        quo    = ACCW'(q0_reg) + ACCW'(rem >= X2W'(div));
        c_next = b_reg;
        c_next.acc = Q30_ONE - quo;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg  <= din;
            pa_reg <= prod_a[30 +: X2W];
        end
        if (en[1])
        begin
            b_reg  <= a_reg;
            pb_reg <= pa_reg;
            q0_reg <= prod_b[RCP_SH +: QW];
        end
        if (en[2])
        begin
            c_reg <= c_next;
        end
    end

    assign dout = c_reg;

endmodule

// ===== hdl/erm_sine_lane.sv =====
// ----------------------------------------------------------------------------
// erm_sine_lane
// Signed q30 sine (or cosine) of one angle: quadrant fold, radian scale,
// square, a chain of six series cells and the final product.
// ----------------------------------------------------------------------------
module erm_sine_lane
    import erm_pkg::*;
(
    input  logic                   clk,
    input  logic [LANE_STAGES-1:0] en,
    input  logic [ANGLE_IN_W-1:0]  angle,
    input  logic                   is_cos,
    output q30_t                   sine
);

    logic [ANGLE_BITS-1:0] ang;
    logic [1:0]            quad;
    logic [RR_W-1:0]       rr;
    logic [RR_W+XW-1:0]    prod1;
    logic [61:0]           prod2;
    logic [61:0]           prodf;

    logic [RR_W-1:0] rr_reg;
    logic            neg0_reg;
    logic [XW-1:0]   x1_reg;
    logic            neg1_reg;
    sine_data_t      d2_reg;
    q30_t            sine_reg;
    sine_data_t      link [NUM_TERMS+1];

    // cosine is the sine a quarter turn further on
    always_comb
    begin
        ang  = ANGLE_BITS'(angle) + (is_cos ? QUARTER_TURN : '0);
        quad = ang[ANGLE_BITS-1 -: 2];
        rr   = quad[0] ? QUARTER_RR - {1'b0, ang[ANGLE_BITS-3:0]}
                       : {1'b0, ang[ANGLE_BITS-3:0]};
    end

    assign prod1 = (RR_W+XW)'(rr_reg) * (RR_W+XW)'(HALF_PI_Q30);
    assign prod2 = 62'(x1_reg) * 62'(x1_reg);
    assign prodf = 62'(link[NUM_TERMS].x) * 62'(link[NUM_TERMS].acc);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rr_reg   <= rr;
            neg0_reg <= quad[1];
        end
        if (en[1])
        begin
            x1_reg   <= prod1[ANGLE_BITS-2 +: XW];
            neg1_reg <= neg0_reg;
        end
        if (en[2])
        begin
            d2_reg.x   <= x1_reg;
            d2_reg.x2  <= prod2[30 +: X2W];
            d2_reg.acc <= Q30_ONE;
            d2_reg.neg <= neg1_reg;
        end
        if (en[LANE_STAGES-1])
        begin
            sine_reg <= link[NUM_TERMS].neg ? -q30_t'({1'b0, prodf[30 +: XW]})
                                            : q30_t'({1'b0, prodf[30 +: XW]});
        end
    end

    assign link[0] = d2_reg;

    for (genvar g = 0; g < NUM_TERMS; g++)
    begin : g_cell
        erm_series_cell u_cell (
            .clk      (clk),
            .en       (en[3 + CELL_STAGES*g +: CELL_STAGES]),
            .term_idx (TERM_IDX_W'(g)),
            .din      (link[g]),
            .dout     (link[g+1])
        );
    end

    assign sine = sine_reg;

endmodule
